>>> rtl/ivt_pkg.sv
package ivt_pkg;

   // Table geometry
   localparam int DEPTH = 16;
   localparam int WIDTH = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Channel field widths
   localparam int OPCODE_W = 4;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int FIDX_W   = 4;
   localparam int COUNT_W  = 5;

   // Width used to compare a request position against the fill count
   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   typedef logic [WIDTH-1:0] word_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH         = 4'd0,
      OP_POP          = 4'd1,
      OP_GET          = 4'd2,
      OP_SET          = 4'd3,
      OP_INSERT       = 4'd4,
      OP_REMOVE_AT    = 4'd5,
      OP_REMOVE_VALUE = 4'd6,
      OP_FIND         = 4'd7,
      OP_CLEAR        = 4'd8
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_RANGE    = 3'd1,
      ST_FULL     = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic slot_free;
   } dp_status_type;

endpackage

>>> rtl/ivt_req_if.sv
interface ivt_req_if;
   import ivt_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [POS_W-1:0]    position;
   logic [VALUE_W-1:0]  elem_value;

   modport source (output valid, output opcode, output position, output elem_value,
                   input ready);
   modport sink   (input valid, input opcode, input position, input elem_value,
                   output ready);
endinterface

>>> rtl/ivt_rsp_if.sv
interface ivt_rsp_if;
   import ivt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  read_value;
   logic [FIDX_W-1:0]   found_index;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output read_value, output found_index,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input read_value, input found_index,
                   input entry_count, output ready);
endinterface

>>> rtl/ivt_ctrl.sv
module ivt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ivt_pkg::dp_status_type dp_stat,
   output ivt_pkg::ctrl_cmd_type  cmd
);
   import ivt_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Take a request in idle, commit it once the result slot is free
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (dp_stat.slot_free) begin
               cmd.execute = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/ivt_datapath.sv
module ivt_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  ivt_pkg::ctrl_cmd_type          cmd,
   output ivt_pkg::dp_status_type         dp_stat,
   input  logic [ivt_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [ivt_pkg::POS_W-1:0]      req_position,
   input  logic [ivt_pkg::VALUE_W-1:0]    req_elem_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ivt_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ivt_pkg::VALUE_W-1:0]    rsp_read_value,
   output logic [ivt_pkg::FIDX_W-1:0]     rsp_found_index,
   output logic [ivt_pkg::COUNT_W-1:0]    rsp_entry_count
);
   import ivt_pkg::*;

   // Table cells and fill count
   word_type entries_ff [DEPTH];
   word_type entries_in [DEPTH];
   cnt_type  count_ff;
   cnt_type  count_in;

   // Captured request and per-cell match flags
   opcode_type       op_ff;
   logic [POS_W-1:0] pos_ff;
   word_type         val_ff;
   logic [DEPTH-1:0] match_ff;
   logic [DEPTH-1:0] match_in;

   // Result register
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   status_type status_ff;
   status_type status_in;
   word_type   read_ff;
   word_type   read_in;
   idx_type    fidx_ff;
   idx_type    fidx_in;

   // Execute-cycle decode
   logic     pos_lt_count;
   logic     pos_le_count;
   logic     full;
   logic     empty;
   logic     hit;
   idx_type  hit_idx;
   idx_type  pos_idx;
   idx_type  last_idx;
   idx_type  rd_addr;
   word_type rd_word;
   logic     wr_en;
   logic     up_en;
   idx_type  wr_idx;
   logic     rm_en;
   idx_type  rm_idx;

   // Compare every live cell against the incoming value
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (entries_ff[i] == req_elem_value[WIDTH-1:0]) &&
                       (CNT_W'(i) < count_ff);
      end
   end

   // Capture the request with its match flags
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= opcode_type'(req_opcode);
         pos_ff   <= req_position;
         val_ff   <= req_elem_value[WIDTH-1:0];
         match_ff <= match_in;
      end
   end

   // Pick the lowest matching index
   always_comb begin
      hit     = |match_ff;
      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign pos_lt_count = CMP_W'(pos_ff) <  CMP_W'(count_ff);
   assign pos_le_count = CMP_W'(pos_ff) <= CMP_W'(count_ff);
   assign full         = (count_ff == CNT_W'(DEPTH));
   assign empty        = (count_ff == '0);
   assign pos_idx      = IDX_W'(pos_ff);
   assign last_idx     = IDX_W'(count_ff - CNT_W'(1));
   assign rd_addr      = (op_ff == OP_POP) ? last_idx : pos_idx;
   assign rd_word      = entries_ff[rd_addr];

   // Decode the operation into status, read data and cell commands
   always_comb begin
      status_in = ST_OK;
      read_in   = '0;
      fidx_in   = '0;
      count_in  = count_ff;
      wr_en     = 1'b0;
      up_en     = 1'b0;
      wr_idx    = pos_idx;
      rm_en     = 1'b0;
      rm_idx    = pos_idx;
      case (op_ff)
         OP_PUSH: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_idx   = IDX_W'(count_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               read_in  = rd_word;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_GET: begin
            if (!pos_lt_count) begin
               status_in = ST_RANGE;
            end else begin
               read_in = rd_word;
            end
         end
         OP_SET: begin
            if (!pos_lt_count) begin
               status_in = ST_RANGE;
            end else begin
               wr_en = 1'b1;
            end
         end
         OP_INSERT: begin
            if (!pos_le_count) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               up_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE_AT: begin
            if (!pos_lt_count) begin
               status_in = ST_RANGE;
            end else begin
               rm_en    = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_REMOVE_VALUE: begin
            if (!hit) begin
               status_in = ST_NOTFOUND;
            end else begin
               rm_en    = 1'b1;
               rm_idx   = hit_idx;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_FIND: begin
            if (!hit) begin
               status_in = ST_NOTFOUND;
            end else begin
               fidx_in = hit_idx;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Per-cell next value: write, shift up for insert, shift down for remove
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      always_comb begin
         entries_in[g] = entries_ff[g];
         if (wr_en && (IDX_W'(g) == wr_idx)) begin
            entries_in[g] = val_ff;
         end else if (up_en && (IDX_W'(g) > wr_idx)) begin
            if (g > 0) begin
               entries_in[g] = entries_ff[(g > 0) ? g - 1 : 0];
            end
         end else if (rm_en && (IDX_W'(g) >= rm_idx)) begin
            if (g < DEPTH - 1) begin
               entries_in[g] = entries_ff[(g < DEPTH - 1) ? g + 1 : g];
            end
         end
      end
   end

   // Commit the cells
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         for (int i = 0; i < DEPTH; i++) begin
            entries_ff[i] <= entries_in[i];
         end
      end
   end

   // Advance the fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   // Load the result; drop valid once taken
   assign rsp_valid_in = cmd.execute | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         read_ff   <= read_in;
         fidx_ff   <= fidx_in;
      end
   end

   // The count only moves on execute, which waits for the slot to empty
   assign dp_stat.slot_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_read_value    = VALUE_W'(read_ff);
   assign rsp_found_index   = FIDX_W'(fidx_ff);
   assign rsp_entry_count   = COUNT_W'(count_ff);

endmodule

>>> rtl/indexed_vector_table_unit.sv
// Channel   Dir  Handshake       Payload
// req_if    in   valid / ready   opcode, position, elem_value
// rsp_if    out  valid / ready   status, read_value, found_index, entry_count
//
// The accept edge registers the request along with a compare of every cell against
// elem_value; the execute state then commits the cell update and loads the result
// register once rsp_if is free. No new request is accepted before that commit.
// Reset clears the fill count and the result valid; cell contents are not reset.
// A waiting result does not block intake; a second result waits in the commit
// cycle until rsp_if is free.
module indexed_vector_table_unit (
   input logic      clock,
   input logic      reset,
   ivt_req_if.sink  req_if,
   ivt_rsp_if.source rsp_if
);
   import ivt_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_stat;

   ivt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   ivt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .dp_stat         (dp_stat),
      .req_opcode      (req_if.opcode),
      .req_position    (req_if.position),
      .req_elem_value  (req_if.elem_value),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_status      (rsp_if.status),
      .rsp_read_value  (rsp_if.read_value),
      .rsp_found_index (rsp_if.found_index),
      .rsp_entry_count (rsp_if.entry_count)
   );

   // Intake closes for the commit cycle after every accept
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted during commit cycle");

   // The count never passes the capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.entry_count <= COUNT_W'(DEPTH)))
      else $error("entry count beyond capacity");

   // A full refusal only happens with a full table
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status == ST_FULL) |-> (rsp_if.entry_count == COUNT_W'(DEPTH)))
      else $error("full status with free space");

   // Failed operations return no data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != ST_OK) |->
         (rsp_if.read_value == '0 && rsp_if.found_index == '0))
      else $error("data returned with error status");

endmodule
